### rtl/core/trial_division_prime_test_macros.svh
// Assertion macros for the checker file of the prime test block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// same-cycle implication, held off during reset
`define TDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define TDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/tdp_pkg.sv
// Package of the trial-division prime test: shared types and constants.
// Depends on nothing; used by tdp_divider and trial_division_prime_test.
`default_nettype none

package tdp_pkg;

  // status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int unsigned SmallestPrime = 2;
  localparam int unsigned FirstDivisor  = 3;
  localparam int unsigned DivisorStep   = 2;

endpackage

`default_nettype wire

### rtl/core/tdp_divider.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on tdp_pkg for the status struct.
`default_nettype none

module tdp_divider #(
  parameter int unsigned W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [W-1:0]      dividend_i,
  input  wire logic [W-1:0]      divisor_i,
  output tdp_pkg::div_stat_t     stat_o,
  output logic [W-1:0]           quotient_o,
  output logic [W-1:0]           remainder_o
);
  import tdp_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      trial;
  logic [W:0]      diff;

  // partial remainder stays below the divisor, so the trial fits in W+1 bits
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    if (!diff[W]) begin
      rem_d = diff[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = trial[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

`default_nettype wire

### rtl/core/trial_division_prime_test.sv
// Negative, small or even values are decided without the divider; otherwise
//   one division runs for each of k odd trial divisors (k <= about 23170 at 32 bits).
// Throughput: one transaction at a time, set by the one shared bit-serial divider.
// A finished result waits in the output register while the next transaction is taken.
// Reset: rst_ni, asynchronous active low, clears the sequencer and output valid.
`default_nettype none

module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               is_prime_o
);
  import tdp_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StLaunch = 2'd1;
  localparam logic [1:0] StWait   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [W-1:0] value_q;
  logic [W-1:0] dvs_q, dvs_d;
  logic         res_q, res_d;
  logic         out_valid_q;
  logic         out_prime_q;
  logic         in_accept;
  logic         out_free;
  logic [W-1:0] value_u;
  logic         div_start;
  div_stat_t    div_stat;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;

  assign value_u   = value_i;
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = (state_q == StLaunch);

  always_comb begin
    state_d = state_q;
    dvs_d   = dvs_q;
    res_d   = res_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          dvs_d = W'(FirstDivisor);
          if (value_u[W-1] || (value_u < W'(SmallestPrime))) begin
            res_d   = 1'b0;
            state_d = StFinish;
          end else if (value_u == W'(SmallestPrime)) begin
            res_d   = 1'b1;
            state_d = StFinish;
          end else if (!value_u[0]) begin
            res_d   = 1'b0;
            state_d = StFinish;
          end else begin
            state_d = StLaunch;
          end
        end
      end
      StLaunch: begin
        state_d = StWait;
      end
      StWait: begin
        if (div_stat.done) begin
          // past the square root: no divisor found
          if (dvs_q > div_quo) begin
            res_d   = 1'b1;
            state_d = StFinish;
          end else if (div_rem == '0) begin
            res_d   = 1'b0;
            state_d = StFinish;
          end else begin
            dvs_d   = dvs_q + W'(DivisorStep);
            state_d = StLaunch;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StFinish && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    res_q <= res_d;
    if (in_accept) begin
      value_q <= value_u;
    end
    if (state_q == StFinish && out_free) begin
      out_prime_q <= res_q;
    end
  end

  tdp_divider #(
    .W (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (value_q),
    .divisor_i   (dvs_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_prime_q;

endmodule

`default_nettype wire

### rtl/core/tdp_checker.sv
// Port-level checker for trial_division_prime_test, attached by bind.
// Depends on trial_division_prime_test_macros.svh for the assertion macros.
`default_nettype none

`include "trial_division_prime_test_macros.svh"

module tdp_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic signed [VALUE_WIDTH-1:0] value_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          is_prime_o
);

  // hold a stalled result
  `TDP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(is_prime_o))

  // one transaction at a time: stall right after an accept
  `TDP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o,
                   in_stall_o)

  // a new result appears only as the sequencer returns to idle
  `TDP_ASSERT_NOW(a_result_frees_input, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

  // an accepted value is consumed; the input side is busy, not the output
  `TDP_ASSERT_NEXT(a_negative_rejected, clk_i, rst_ni,
                   in_valid_i && !in_stall_o && value_i[VALUE_WIDTH-1] && !out_valid_o,
                   in_stall_o && !out_valid_o)

endmodule

bind trial_division_prime_test tdp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tdp_checker (.*);

`default_nettype wire
